// ===== sv/clft_pkg.sv =====
// ----------------------------------------------------------------------------
// clft_pkg
// Types, character codes and helpers for the command line field tokenizer.
// ----------------------------------------------------------------------------
package clft_pkg;

    localparam int MAX_FIELDS  = 8;
    localparam int FIELD_CHARS = 32;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;

    localparam int HEX_LENGTH = 6;
    localparam int DEC_RADIX  = 10;
    localparam int HEX_RADIX  = 16;

    localparam logic [31:0] DEC_POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] DEC_NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        DEC_SKIP,
        DEC_SIGN,
        DEC_DIGITS,
        DEC_DONE
    } dec_phase_t;

    typedef enum logic [2:0] {
        HEX_SKIP,
        HEX_SIGN,
        HEX_ZERO,
        HEX_PREFIX,
        HEX_DIGITS,
        HEX_DONE
    } hex_phase_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic hex_digit_t hex_digit(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d.value = 4'(c - CHAR_ZERO);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.value = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.value = 4'(c - 8'h41 + 8'd10);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== sv/command_line_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_field_tokenizer
// Splits a byte stream into space separated fields and reports, for each
// field, its index, length, decimal value and hex colour value (six character fields).
//
//   channel  direction  signals                               item
//   input    in         in_valid, in_ready, rx_byte           one character
//   output   out        out_valid, out_ready, field_number,   one closed field
//                       field_length, decimal_value,
//                       colour_value, too_many_fields,
//                       field_too_long, last_field
//
// One character per cycle while in_ready is high; a space or newline gives its field
// result in the cycle after acceptance, from the result register.
// Parsing state updates in the same cycle as acceptance, one step per byte.
// in_ready is low only while the result register holds an item not yet taken.
// Reset clears all field and line state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module command_line_field_tokenizer
    import clft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         field_number,
    output logic [5:0]         field_length,
    output logic signed [31:0] decimal_value,
    output logic signed [24:0] colour_value,
    output logic               too_many_fields,
    output logic               field_too_long,
    output logic               last_field
);

    localparam int FCW = $clog2(MAX_FIELDS + 1);
    localparam int CCW = $clog2(FIELD_CHARS + 1);

    logic [FCW-1:0] field_count_reg,  field_count_next;
    logic [CCW-1:0] char_count_reg,   char_count_next;
    logic [31:0]    dec_mag_reg,      dec_mag_next;
    dec_phase_t     dec_phase_reg,    dec_phase_next;
    logic           dec_neg_reg,      dec_neg_next;
    logic           dec_sat_reg,      dec_sat_next;
    logic [23:0]    hex_mag_reg,      hex_mag_next;
    hex_phase_t     hex_phase_reg,    hex_phase_next;
    logic           hex_neg_reg,      hex_neg_next;

    logic               out_valid_reg,    out_valid_next;
    logic [2:0]         field_number_reg;
    logic [5:0]         field_length_reg;
    logic signed [31:0] decimal_value_reg;
    logic signed [24:0] colour_value_reg;
    logic               too_many_reg;
    logic               too_long_reg;
    logic               last_field_reg;

    logic           in_accept;
    logic           is_space;
    logic           is_newline;
    logic           emit;
    logic           digit;
    logic [3:0]     dec_d;
    logic [35:0]    dec_prod;
    hex_digit_t     hd;
    logic [23:0]    hex_acc;

    logic [FCW-1:0] idx_sat;
    logic [31:0]    dec_limit;
    logic [31:0]    dec_result;
    logic [24:0]    col_result;

    assign in_ready   = !out_valid_reg || out_ready;
    assign in_accept  = in_valid && in_ready;
    assign is_space   = (rx_byte == CHAR_SPACE);
    assign is_newline = (rx_byte == CHAR_NEWLINE);
    assign emit       = in_accept && (is_space || is_newline);

    assign digit    = is_decimal(rx_byte);
    assign dec_d    = 4'(rx_byte - CHAR_ZERO);
    assign dec_prod = 36'(dec_mag_reg) * 36'(DEC_RADIX) + 36'(dec_d);
    assign hd       = hex_digit(rx_byte);
    assign hex_acc  = 24'(hex_mag_reg * 24'(HEX_RADIX)) | 24'(hd.value);

    // field result from the state before this byte
    always_comb
    begin
        idx_sat   = (field_count_reg >= FCW'(MAX_FIELDS)) ? FCW'(MAX_FIELDS - 1)
                                                          : field_count_reg;
        dec_limit = dec_neg_reg ? DEC_NEG_LIMIT : DEC_POS_LIMIT;
        if (dec_sat_reg || dec_mag_reg > dec_limit)
        begin
            dec_result = dec_limit;
        end
        else
        begin
            dec_result = dec_neg_reg ? (32'd0 - dec_mag_reg) : dec_mag_reg;
        end
        if (char_count_reg == CCW'(HEX_LENGTH))
        begin
            col_result = hex_neg_reg ? (25'd0 - {1'b0, hex_mag_reg}) : {1'b0, hex_mag_reg};
        end
        else
        begin
            col_result = 25'd0;
        end
    end

    always_comb
    begin
        field_count_next = field_count_reg;
        char_count_next  = char_count_reg;
        dec_mag_next     = dec_mag_reg;
        dec_phase_next   = dec_phase_reg;
        dec_neg_next     = dec_neg_reg;
        dec_sat_next     = dec_sat_reg;
        hex_mag_next     = hex_mag_reg;
        hex_phase_next   = hex_phase_reg;
        hex_neg_next     = hex_neg_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end

        if (in_accept)
        begin
            if (is_newline || is_space)
            begin
                if (is_newline)
                begin
                    field_count_next = '0;
                end
                else if (field_count_reg < FCW'(MAX_FIELDS))
                begin
                    field_count_next = field_count_reg + 1'b1;
                end
                char_count_next = '0;
                dec_mag_next    = '0;
                dec_phase_next  = DEC_SKIP;
                dec_neg_next    = 1'b0;
                dec_sat_next    = 1'b0;
                hex_mag_next    = '0;
                hex_phase_next  = HEX_SKIP;
                hex_neg_next    = 1'b0;
            end
            else
            begin
                if (char_count_reg < CCW'(FIELD_CHARS - 1))
                begin
                    // decimal prefix
                    unique case (dec_phase_reg)
                        DEC_SKIP:
                        begin
                            if (is_blank(rx_byte))
                            begin
                                dec_phase_next = DEC_SKIP;
                            end
                            else if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS)
                            begin
                                dec_neg_next   = (rx_byte == CHAR_MINUS);
                                dec_phase_next = DEC_SIGN;
                            end
                            else if (digit)
                            begin
                                dec_phase_next = DEC_DIGITS;
                                if (!dec_sat_reg)
                                begin
                                    if (dec_prod > 36'(DEC_NEG_LIMIT))
                                        dec_sat_next = 1'b1;
                                    else
                                        dec_mag_next = dec_prod[31:0];
                                end
                            end
                            else
                            begin
                                dec_phase_next = DEC_DONE;
                            end
                        end
                        DEC_SIGN, DEC_DIGITS:
                        begin
                            if (digit)
                            begin
                                dec_phase_next = DEC_DIGITS;
                                if (!dec_sat_reg)
                                begin
                                    if (dec_prod > 36'(DEC_NEG_LIMIT))
                                        dec_sat_next = 1'b1;
                                    else
                                        dec_mag_next = dec_prod[31:0];
                                end
                            end
                            else
                            begin
                                dec_phase_next = DEC_DONE;
                            end
                        end
                        default:
                        begin
                            dec_phase_next = dec_phase_reg;
                        end
                    endcase

                    // hex prefix with optional 0x
                    unique case (hex_phase_reg)
                        HEX_SKIP, HEX_SIGN:
                        begin
                            if (hex_phase_reg == HEX_SKIP && is_blank(rx_byte))
                            begin
                                hex_phase_next = HEX_SKIP;
                            end
                            else if (hex_phase_reg == HEX_SKIP &&
                                     (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS))
                            begin
                                hex_neg_next   = (rx_byte == CHAR_MINUS);
                                hex_phase_next = HEX_SIGN;
                            end
                            else if (rx_byte == CHAR_ZERO)
                            begin
                                hex_phase_next = HEX_ZERO;
                            end
                            else if (hd.valid)
                            begin
                                hex_mag_next   = hex_acc;
                                hex_phase_next = HEX_DIGITS;
                            end
                            else
                            begin
                                hex_phase_next = HEX_DONE;
                            end
                        end
                        HEX_ZERO:
                        begin
                            if (rx_byte == CHAR_LOWER_X || rx_byte == CHAR_UPPER_X)
                            begin
                                hex_phase_next = HEX_PREFIX;
                            end
                            else if (hd.valid)
                            begin
                                hex_mag_next   = hex_acc;
                                hex_phase_next = HEX_DIGITS;
                            end
                            else
                            begin
                                hex_phase_next = HEX_DONE;
                            end
                        end
                        HEX_PREFIX, HEX_DIGITS:
                        begin
                            if (hd.valid)
                            begin
                                hex_mag_next   = hex_acc;
                                hex_phase_next = HEX_DIGITS;
                            end
                            else
                            begin
                                hex_phase_next = HEX_DONE;
                            end
                        end
                        default:
                        begin
                            hex_phase_next = hex_phase_reg;
                        end
                    endcase
                end
                if (char_count_reg < CCW'(FIELD_CHARS))
                begin
                    char_count_next = char_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg <= '0;
            char_count_reg  <= '0;
            dec_mag_reg     <= '0;
            dec_phase_reg   <= DEC_SKIP;
            dec_neg_reg     <= 1'b0;
            dec_sat_reg     <= 1'b0;
            hex_mag_reg     <= '0;
            hex_phase_reg   <= HEX_SKIP;
            hex_neg_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            field_count_reg <= field_count_next;
            char_count_reg  <= char_count_next;
            dec_mag_reg     <= dec_mag_next;
            dec_phase_reg   <= dec_phase_next;
            dec_neg_reg     <= dec_neg_next;
            dec_sat_reg     <= dec_sat_next;
            hex_mag_reg     <= hex_mag_next;
            hex_phase_reg   <= hex_phase_next;
            hex_neg_reg     <= hex_neg_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            field_number_reg  <= 3'(idx_sat);
            field_length_reg  <= 6'(char_count_reg);
            decimal_value_reg <= dec_result;
            colour_value_reg  <= col_result;
            too_many_reg      <= (field_count_reg >= FCW'(MAX_FIELDS));
            too_long_reg      <= (char_count_reg > CCW'(FIELD_CHARS - 1));
            last_field_reg    <= is_newline;
        end
    end

    assign out_valid       = out_valid_reg;
    assign field_number    = field_number_reg;
    assign field_length    = field_length_reg;
    assign decimal_value   = decimal_value_reg;
    assign colour_value    = colour_value_reg;
    assign too_many_fields = too_many_reg;
    assign field_too_long  = too_long_reg;
    assign last_field      = last_field_reg;

    a_newline_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && is_newline |=> field_count_reg == '0 && char_count_reg == '0)
        else $error("line state not cleared after newline");

    a_separator_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("separator accepted without a result");

    a_char_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= CCW'(FIELD_CHARS))
        else $error("character count past saturation");

    a_colour_needs_six: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && colour_value_reg != '0 |-> field_length_reg == 6'(HEX_LENGTH))
        else $error("colour value on a field that is not six characters");

    a_index_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && too_many_reg |-> field_number_reg == 3'(MAX_FIELDS - 1))
        else $error("index not saturated on excess field");

endmodule
